>>> rtl/core/qfbm_pkg.sv
// ----------------------------------------------------------------------------
// qfbm_pkg
// Shared types and constants of the QoS flow to bearer mapper: operation and
// status codes, register map, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package qfbm_pkg;

  // default number of flow table entries
  localparam int unsigned TableEntriesDef = 64;

  // field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned FlowW   = 8;
  localparam int unsigned QfiW    = 6;
  localparam int unsigned BearerW = 7;
  localparam int unsigned HdrW    = 8;
  localparam int unsigned StatusW = 2;

  // register port
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] REG_ENTITY_ACTIVE  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_DEFAULT_ENABLE = 2'd1;
  localparam logic [RegIdxW-1:0] REG_DEFAULT_BEARER = 2'd2;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_MAP      = 3'd0,
    OP_UNMAP    = 3'd1,
    OP_UPDATE   = 3'd2,
    OP_UPLINK   = 3'd3,
    OP_DOWNLINK = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // payload of one table entry (valid mark is held apart in flops)
  typedef struct packed {
    logic [QfiW-1:0]    qfi;
    logic [BearerW-1:0] bearer;
    logic               refl;
  } entry_t;

  // configuration register contents
  typedef struct packed {
    logic               entity_active;
    logic               default_enable;
    logic [BearerW-1:0] default_bearer;
  } cfg_t;

endpackage

>>> rtl/core/qos_flow_to_bearer_mapper.sv
// ----------------------------------------------------------------------------
// qos_flow_to_bearer_mapper
// Flow table that maps QoS flow ids to bearers and builds and parses the
// one-byte flow header for uplink and downlink beats.
// ----------------------------------------------------------------------------
// one beat in flight: a new beat is taken only once the last one has scanned
// the table memory through its single read port, one entry per cycle, and
//   loaded its result
// a finished result waits in the output register while the next beat is taken
// reset: all entries invalid at once, control registers zero, no clearing pass
module qos_flow_to_bearer_mapper #(
  parameter int unsigned TableEntries = qfbm_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qfbm_pkg::PaddrW-1:0]   paddr,
  input  logic [qfbm_pkg::PdataW-1:0]   pwdata,
  output logic [qfbm_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [qfbm_pkg::OpW-1:0]      op_i,
  input  logic [qfbm_pkg::FlowW-1:0]    flow_id_i,
  input  logic [qfbm_pkg::BearerW-1:0]  bearer_id_i,
  input  logic                          reflective_i,
  input  logic [qfbm_pkg::HdrW-1:0]     rx_header_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qfbm_pkg::StatusW-1:0]  status_o,
  output logic [qfbm_pkg::BearerW-1:0]  out_bearer_o,
  output logic [qfbm_pkg::HdrW-1:0]     tx_header_o,
  output logic [qfbm_pkg::QfiW-1:0]     out_flow_id_o,
  output logic                          out_reflective_o
);
  import qfbm_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  cfg_t            cfg;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;
  logic            rd_valid;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic            set_valid;
  logic            clr_valid;

  // configuration registers
  qfbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // flow table storage
  qfbm_table #(
    .TableEntries (TableEntries)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .rd_valid_o  (rd_valid),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .set_valid_i (set_valid),
    .clr_valid_i (clr_valid)
  );

  // operation sequencer
  qfbm_ctrl #(
    .TableEntries (TableEntries)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .flow_id_i        (flow_id_i),
    .bearer_id_i      (bearer_id_i),
    .reflective_i     (reflective_i),
    .rx_header_i      (rx_header_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .out_bearer_o     (out_bearer_o),
    .tx_header_o      (tx_header_o),
    .out_flow_id_o    (out_flow_id_o),
    .out_reflective_o (out_reflective_o),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .rd_valid_i       (rd_valid),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .set_valid_o      (set_valid),
    .clr_valid_o      (clr_valid)
  );

endmodule

>>> rtl/core/qfbm_regs.sv
// ----------------------------------------------------------------------------
// qfbm_regs
// APB-style configuration registers: entity active, default bearer enable and
// default bearer. Zero wait states, writes on the access phase.
// ----------------------------------------------------------------------------
module qfbm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qfbm_pkg::PaddrW-1:0] paddr,
  input  logic [qfbm_pkg::PdataW-1:0] pwdata,
  output logic [qfbm_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output qfbm_pkg::cfg_t              cfg_o
);
  import qfbm_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic [RegIdxW-1:0] reg_idx;
  logic             wr_fire;

  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_fire = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_fire) begin
      case (reg_idx)
        REG_ENTITY_ACTIVE:  cfg_d.entity_active  = pwdata[0];
        REG_DEFAULT_ENABLE: cfg_d.default_enable = pwdata[0];
        REG_DEFAULT_BEARER: cfg_d.default_bearer = pwdata[BearerW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ENTITY_ACTIVE:  prdata = PdataW'(cfg_q.entity_active);
      REG_DEFAULT_ENABLE: prdata = PdataW'(cfg_q.default_enable);
      REG_DEFAULT_BEARER: prdata = PdataW'(cfg_q.default_bearer);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/qfbm_table.sv
// ----------------------------------------------------------------------------
// qfbm_table
// Flow table storage: a synchronous single-port-read memory for entry payload
// and one valid flop per entry, cleared at reset. Read data is registered.
// ----------------------------------------------------------------------------
module qfbm_table #(
  parameter int unsigned TableEntries = qfbm_pkg::TableEntriesDef,
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  output qfbm_pkg::entry_t     rd_data_o,
  output logic                 rd_valid_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  qfbm_pkg::entry_t     wr_data_i,
  input  logic                 set_valid_i,
  input  logic                 clr_valid_i
);
  import qfbm_pkg::*;

  entry_t mem_q [TableEntries];
  logic   valid_q [TableEntries];
  entry_t rd_data_q;
  logic   rd_valid_q;

  // payload memory, written and read in one clocked block
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // valid marks and registered valid read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) begin
        valid_q[i] <= 1'b0;
      end
      rd_valid_q <= 1'b0;
    end else begin
      if (set_valid_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (clr_valid_i) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

>>> rtl/core/qfbm_ctrl.sv
// ----------------------------------------------------------------------------
// qfbm_ctrl
// Operation sequencer: takes one beat, scans the flow table one entry per
// cycle for the first match and the first free slot, then writes back the
// table change and loads the result register.
// ----------------------------------------------------------------------------
module qfbm_ctrl #(
  parameter int unsigned TableEntries = qfbm_pkg::TableEntriesDef,
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1,
  localparam int unsigned CntW = $clog2(TableEntries + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qfbm_pkg::cfg_t                 cfg_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [qfbm_pkg::OpW-1:0]       op_i,
  input  logic [qfbm_pkg::FlowW-1:0]     flow_id_i,
  input  logic [qfbm_pkg::BearerW-1:0]   bearer_id_i,
  input  logic                           reflective_i,
  input  logic [qfbm_pkg::HdrW-1:0]      rx_header_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [qfbm_pkg::StatusW-1:0]   status_o,
  output logic [qfbm_pkg::BearerW-1:0]   out_bearer_o,
  output logic [qfbm_pkg::HdrW-1:0]      tx_header_o,
  output logic [qfbm_pkg::QfiW-1:0]      out_flow_id_o,
  output logic                           out_reflective_o,
  // table port
  output logic                           rd_en_o,
  output logic [IdxW-1:0]                rd_addr_o,
  input  qfbm_pkg::entry_t               rd_data_i,
  input  logic                           rd_valid_i,
  output logic                           wr_en_o,
  output logic [IdxW-1:0]                wr_addr_o,
  output qfbm_pkg::entry_t               wr_data_o,
  output logic                           set_valid_o,
  output logic                           clr_valid_o
);
  import qfbm_pkg::*;

  state_e state_q, state_d;

  // captured item
  logic [OpW-1:0]     op_q;
  logic [FlowW-1:0]   flow_q;
  logic [BearerW-1:0] bearer_q;
  logic               refl_q;
  logic [HdrW-1:0]    hdr_q;

  // scan bookkeeping
  logic [CntW-1:0]    iss_q;
  logic               chk_v_q;
  logic [IdxW-1:0]    chk_idx_q;
  logic               hit_q;
  logic [IdxW-1:0]    hit_idx_q;
  entry_t             hit_ent_q;
  logic               free_q;
  logic [IdxW-1:0]    free_idx_q;

  // result register
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [BearerW-1:0] ob_q;
  logic [HdrW-1:0]    txh_q;
  logic [QfiW-1:0]    ofid_q;
  logic               orefl_q;

  logic [StatusW-1:0] res_status;
  logic [BearerW-1:0] res_ob;
  logic [HdrW-1:0]    res_txh;
  logic [QfiW-1:0]    res_ofid;
  logic               res_orefl;

  logic in_fire, issue, last_chk, flow_ok, entry_match, done_fire;

  assign in_fire   = in_valid_i & in_ready_o;
  assign issue     = (state_q == ST_SCAN) && (iss_q < CntW'(TableEntries));
  assign last_chk  = chk_v_q && (chk_idx_q == IdxW'(TableEntries - 1));
  assign flow_ok   = (flow_q[FlowW-1:QfiW] == '0);
  assign entry_match = rd_valid_i && flow_ok && (rd_data_i.qfi == flow_q[QfiW-1:0]);
  assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire)   state_d = ST_SCAN;
      ST_SCAN: if (last_chk)  state_d = ST_DONE;
      ST_DONE: if (done_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result and write-back decode
  always_comb begin
    res_status = STAT_INVALID;
    res_ob     = '0;
    res_txh    = '0;
    res_ofid   = '0;
    res_orefl  = 1'b0;
    wr_en_o     = 1'b0;
    wr_addr_o   = free_idx_q;
    wr_data_o   = '{qfi: flow_q[QfiW-1:0], bearer: bearer_q, refl: refl_q};
    set_valid_o = 1'b0;
    clr_valid_o = 1'b0;
    case (op_q)
      OP_MAP: begin
        if (!flow_ok) begin
          res_status = STAT_INVALID;
        end else if (free_q) begin
          res_status  = STAT_OK;
          wr_en_o     = done_fire;
          set_valid_o = done_fire;
        end else begin
          res_status = STAT_FULL;
        end
      end
      OP_UNMAP: begin
        wr_addr_o = hit_idx_q;
        if (hit_q) begin
          res_status  = STAT_OK;
          clr_valid_o = done_fire;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      OP_UPDATE: begin
        wr_addr_o = hit_idx_q;
        wr_data_o = '{qfi: hit_ent_q.qfi, bearer: bearer_q, refl: hit_ent_q.refl};
        if (hit_q) begin
          res_status = STAT_OK;
          wr_en_o    = done_fire;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      OP_UPLINK: begin
        if (!cfg_i.entity_active) begin
          res_status = STAT_INVALID;
        end else if (hit_q) begin
          res_status = STAT_OK;
          res_ob     = hit_ent_q.bearer;
          res_txh    = {1'b0, hit_ent_q.refl, flow_q[QfiW-1:0]};
        end else if (cfg_i.default_enable) begin
          res_status = STAT_OK;
          res_ob     = cfg_i.default_bearer;
          res_txh    = {2'b00, flow_q[QfiW-1:0]};
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      OP_DOWNLINK: begin
        res_status = STAT_OK;
        res_ofid   = hdr_q[QfiW-1:0];
        res_orefl  = hdr_q[QfiW];
        wr_data_o  = '{qfi: hdr_q[QfiW-1:0], bearer: bearer_q, refl: 1'b1};
        // reflective flow is mapped silently; full table drops it
        if (hdr_q[QfiW] && free_q) begin
          wr_en_o     = done_fire;
          set_valid_o = done_fire;
        end
      end
      default: res_status = STAT_INVALID;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      chk_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= issue;
      if (in_fire) begin
        iss_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (issue) begin
        iss_q <= iss_q + CntW'(1);
      end
      if (chk_v_q) begin
        if (entry_match && !hit_q) hit_q <= 1'b1;
        if (!rd_valid_i && !free_q) free_q <= 1'b1;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_i;
      flow_q   <= flow_id_i;
      bearer_q <= bearer_id_i;
      refl_q   <= reflective_i;
      hdr_q    <= rx_header_i;
    end
    if (issue) begin
      chk_idx_q <= iss_q[IdxW-1:0];
    end
    // first match and first free slot
    if (chk_v_q && entry_match && !hit_q) begin
      hit_idx_q <= chk_idx_q;
      hit_ent_q <= rd_data_i;
    end
    if (chk_v_q && !rd_valid_i && !free_q) begin
      free_idx_q <= chk_idx_q;
    end
    if (done_fire) begin
      status_q <= res_status;
      ob_q     <= res_ob;
      txh_q    <= res_txh;
      ofid_q   <= res_ofid;
      orefl_q  <= res_orefl;
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign rd_en_o          = issue;
  assign rd_addr_o        = iss_q[IdxW-1:0];
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_bearer_o     = ob_q;
  assign tx_header_o      = txh_q;
  assign out_flow_id_o    = ofid_q;
  assign out_reflective_o = orefl_q;

endmodule

>>> bench/qfbm_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// qfbm_scoreboard_pkg
// Beat types and the scoreboard of the QoS flow to bearer mapper bench: a
// flow table of its own that works out each result, and the store of results
// still due from the block.
// ----------------------------------------------------------------------------
package qfbm_scoreboard_pkg;

  import qfbm_pkg::*;

  localparam logic [FlowW-1:0] QfiMax = FlowW'((1 << QfiW) - 1);

  // one input beat
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [FlowW-1:0]   flow_id;
    logic [BearerW-1:0] bearer_id;
    logic               reflective;
    logic [HdrW-1:0]    rx_header;
  } flow_req_t;

  // one result beat
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [BearerW-1:0] bearer;
    logic [HdrW-1:0]    tx_header;
    logic [QfiW-1:0]    qfi;
    logic               reflective;
  } flow_rsp_t;

  class flow_map_scoreboard;
    bit                 slot_valid  [TableEntriesDef];
    logic [QfiW-1:0]    slot_qfi    [TableEntriesDef];
    logic [BearerW-1:0] slot_bearer [TableEntriesDef];
    logic               slot_refl   [TableEntriesDef];
    cfg_t               regs;
    flow_rsp_t          rsp_due_q[$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < TableEntriesDef; i++) begin
        slot_valid[i]  = 1'b0;
        slot_qfi[i]    = '0;
        slot_bearer[i] = '0;
        slot_refl[i]   = 1'b0;
      end
      regs       = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [PdataW-1:0] val);
      case (idx)
        REG_ENTITY_ACTIVE:  regs.entity_active  = val[0];
        REG_DEFAULT_ENABLE: regs.default_enable = val[0];
        REG_DEFAULT_BEARER: regs.default_bearer = val[BearerW-1:0];
        default: ;
      endcase
    endfunction

    function logic [PdataW-1:0] reg_value(logic [RegIdxW-1:0] idx);
      case (idx)
        REG_ENTITY_ACTIVE:  return PdataW'(regs.entity_active);
        REG_DEFAULT_ENABLE: return PdataW'(regs.default_enable);
        REG_DEFAULT_BEARER: return PdataW'(regs.default_bearer);
        default:            return '0;
      endcase
    endfunction

    // lowest valid slot holding this flow, an id over 63 never matches
    function int lowest_match(logic [FlowW-1:0] fid);
      for (int i = 0; i < TableEntriesDef; i++) begin
        if (slot_valid[i] && FlowW'(slot_qfi[i]) == fid) return i;
      end
      return -1;
    endfunction

    // fills the lowest free slot, no duplicate check
    function logic [StatusW-1:0] add_flow(logic [FlowW-1:0] fid,
                                          logic [BearerW-1:0] bearer, logic refl);
      if (fid > QfiMax) return STAT_INVALID;
      for (int i = 0; i < TableEntriesDef; i++) begin
        if (!slot_valid[i]) begin
          slot_valid[i]  = 1'b1;
          slot_qfi[i]    = fid[QfiW-1:0];
          slot_bearer[i] = bearer;
          slot_refl[i]   = refl;
          return STAT_OK;
        end
      end
      return STAT_FULL;
    endfunction

    // a flow id currently in the table, or the fallback when it is empty
    function logic [FlowW-1:0] pick_mapped(logic [FlowW-1:0] fallback);
      int used_q[$];
      for (int i = 0; i < TableEntriesDef; i++) begin
        if (slot_valid[i]) used_q.push_back(i);
      end
      if (used_q.size() == 0) return fallback;
      return FlowW'(slot_qfi[used_q[$urandom_range(0, used_q.size() - 1)]]);
    endfunction

    // works out the result of an accepted beat and updates the table
    function void note_request(flow_req_t req);
      flow_rsp_t rsp;
      int        hit;
      rsp        = '0;
      rsp.status = STAT_INVALID;
      case (req.op)
        OP_MAP: rsp.status = add_flow(req.flow_id, req.bearer_id, req.reflective);
        OP_UNMAP, OP_UPDATE: begin
          hit = lowest_match(req.flow_id);
          if (hit < 0) begin
            rsp.status = STAT_NOT_FOUND;
          end else begin
            if (req.op == OP_UNMAP) slot_valid[hit] = 1'b0;
            else slot_bearer[hit] = req.bearer_id;
            rsp.status = STAT_OK;
          end
        end
        OP_UPLINK: begin
          if (regs.entity_active) begin
            hit = lowest_match(req.flow_id);
            if (hit >= 0) begin
              rsp.status    = STAT_OK;
              rsp.bearer    = slot_bearer[hit];
              rsp.tx_header = {1'b0, slot_refl[hit], req.flow_id[QfiW-1:0]};
            end else if (regs.default_enable) begin
              rsp.status    = STAT_OK;
              rsp.bearer    = regs.default_bearer;
              rsp.tx_header = {2'b00, req.flow_id[QfiW-1:0]};
            end else begin
              rsp.status = STAT_NOT_FOUND;
            end
          end
        end
        OP_DOWNLINK: begin
          // bit 7 ignored, a reflective header maps its flow quietly
          rsp.qfi        = req.rx_header[QfiW-1:0];
          rsp.reflective = req.rx_header[QfiW];
          if (rsp.reflective) void'(add_flow(FlowW'(rsp.qfi), req.bearer_id, 1'b1));
          rsp.status = STAT_OK;
        end
        default: ;
      endcase
      rsp_due_q.push_back(rsp);
    endfunction

    function void compare_field(string what, logic [PdataW-1:0] want,
                                logic [PdataW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    // compares a result beat with the oldest one due
    function void check_result(flow_rsp_t got);
      flow_rsp_t want;
      if (rsp_due_q.size() == 0) begin
        $display("%0t: result with none due, expected nothing, got 0x%0h", $time, got);
        mismatches++;
        return;
      end
      want = rsp_due_q.pop_front();
      compare_field("status", PdataW'(want.status), PdataW'(got.status));
      compare_field("out_bearer", PdataW'(want.bearer), PdataW'(got.bearer));
      compare_field("tx_header", PdataW'(want.tx_header), PdataW'(got.tx_header));
      compare_field("out_flow_id", PdataW'(want.qfi), PdataW'(got.qfi));
      compare_field("out_reflective", PdataW'(want.reflective), PdataW'(got.reflective));
    endfunction

    function int unsigned pending();
      return rsp_due_q.size();
    endfunction
  endclass

endpackage

>>> bench/tb_qos_flow_to_bearer_mapper.sv
// ----------------------------------------------------------------------------
// tb_qos_flow_to_bearer_mapper
// Drives map, unmap, update, uplink and downlink beats into the flow table,
// directed corner cases first and then random phases under several register
// settings, and checks every result beat against the scoreboard's own table.
// ----------------------------------------------------------------------------
module tb_qos_flow_to_bearer_mapper;

  timeunit 1ns;
  timeprecision 1ps;

  import qfbm_pkg::*;
  import qfbm_scoreboard_pkg::*;

  localparam int unsigned ScanCycles = TableEntriesDef + 3;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned PhaseCount = 8;
  localparam logic [OpW-1:0]     OpCodeMax = '1;
  localparam logic [OpW-1:0]     OpUnknown = OpW'(OP_DOWNLINK + 1);
  localparam logic [FlowW-1:0]   FlowMax   = '1;
  localparam logic [BearerW-1:0] BearerMax = '1;
  localparam logic [HdrW-1:0]    HdrMax    = '1;

  typedef enum logic [1:0] {MIX_CHURN, MIX_FILL, MIX_DRAIN} mix_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BLOCKS} stall_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PaddrW-1:0]  paddr        = '0;
  logic [PdataW-1:0]  pwdata       = '0;
  logic               in_valid_i   = 1'b0;
  logic [OpW-1:0]     op_i         = '0;
  logic [FlowW-1:0]   flow_id_i    = '0;
  logic [BearerW-1:0] bearer_id_i  = '0;
  logic               reflective_i = 1'b0;
  logic [HdrW-1:0]    rx_header_i  = '0;
  logic               out_ready_i  = 1'b0;

  logic [PdataW-1:0]  prdata;
  logic               pready;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [StatusW-1:0] status_o;
  logic [BearerW-1:0] out_bearer_o;
  logic [HdrW-1:0]    tx_header_o;
  logic [QfiW-1:0]    out_flow_id_o;
  logic               out_reflective_o;

  flow_map_scoreboard sb = new();

  int unsigned burst_left   = 1;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  stall_e      stall_mode   = STALL_NONE;

  always #5ns clk_i = ~clk_i;

  qos_flow_to_bearer_mapper #(
    .TableEntries(TableEntriesDef)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .flow_id_i       (flow_id_i),
    .bearer_id_i     (bearer_id_i),
    .reflective_i    (reflective_i),
    .rx_header_i     (rx_header_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_bearer_o    (out_bearer_o),
    .tx_header_o     (tx_header_o),
    .out_flow_id_o   (out_flow_id_o),
    .out_reflective_o(out_reflective_o)
  );

  // result side: check accepted beats, stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({status_o, out_bearer_o, tx_header_o, out_flow_id_o,
                       out_reflective_o});
    end
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_ready_i <= 1'b1;
      STALL_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      STALL_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:      out_ready_i <= (stall_left % 33) < 3;
    endcase
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("FAIL qos_flow_to_bearer_mapper");
      $finish;
    end
  end

  task automatic reg_write(logic [RegIdxW-1:0] idx, logic [PdataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read_check(logic [RegIdxW-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PaddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.compare_field($sformatf("register %0d", idx), sb.reg_value(idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic active, logic dflt_en, logic [BearerW-1:0] dflt_bearer);
    reg_write(REG_ENTITY_ACTIVE, PdataW'(active));
    reg_write(REG_DEFAULT_ENABLE, PdataW'(dflt_en));
    reg_write(REG_DEFAULT_BEARER, PdataW'(dflt_bearer));
    reg_read_check(REG_ENTITY_ACTIVE);
    reg_read_check(REG_DEFAULT_ENABLE);
    reg_read_check(REG_DEFAULT_BEARER);
  endtask

  // stop offering beats and wait for every due result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // offers one beat, then either keeps the burst going or idles a while
  task automatic send_beat(flow_req_t req);
    in_valid_i   <= 1'b1;
    op_i         <= req.op;
    flow_id_i    <= req.flow_id;
    bearer_id_i  <= req.bearer_id;
    reflective_i <= req.reflective;
    rx_header_i  <= req.rx_header;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(req);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        burst_left = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk_i);
      end
    end
  endtask

  function automatic flow_req_t make_req(logic [OpW-1:0] op, logic [FlowW-1:0] fid,
                                         logic [BearerW-1:0] bid, logic refl,
                                         logic [HdrW-1:0] hdr);
    return {op, fid, bid, refl, hdr};
  endfunction

  // random beat, op mix chosen to fill, churn or drain the table
  function automatic flow_req_t random_req(mix_e mix);
    int unsigned      roll;
    int unsigned      map_lim, unmap_lim, update_lim, uplink_lim, dl_lim;
    logic [OpW-1:0]   op;
    logic [FlowW-1:0] fid;
    case (mix)
      MIX_CHURN: begin
        map_lim = 25; unmap_lim = 40; update_lim = 55; uplink_lim = 85; dl_lim = 97;
      end
      MIX_FILL: begin
        map_lim = 65; unmap_lim = 65; update_lim = 70; uplink_lim = 80; dl_lim = 98;
      end
      default: begin
        map_lim = 5; unmap_lim = 55; update_lim = 65; uplink_lim = 90; dl_lim = 98;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < map_lim) op = OP_MAP;
    else if (roll < unmap_lim) op = OP_UNMAP;
    else if (roll < update_lim) op = OP_UPDATE;
    else if (roll < uplink_lim) op = OP_UPLINK;
    else if (roll < dl_lim) op = OP_DOWNLINK;
    else op = OpW'($urandom_range(OpUnknown, OpCodeMax));
    // mostly ids already in the table so lookups hit
    roll = $urandom_range(0, 99);
    if (roll < 55) fid = sb.pick_mapped(FlowW'($urandom_range(0, QfiMax)));
    else if (roll < 88) fid = FlowW'($urandom_range(0, QfiMax));
    else fid = FlowW'($urandom_range(0, FlowMax));
    return make_req(op, fid, BearerW'($urandom_range(0, BearerMax)),
                    1'($urandom_range(0, 1)), HdrW'($urandom_range(0, HdrMax)));
  endfunction

  // corner cases, registers still at reset values at the start
  task automatic directed();
    send_beat(make_req(OP_UPLINK, 8'd5, 7'd1, 1'b0, 8'h00));
    send_beat(make_req(OP_UNMAP, 8'd5, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPDATE, 8'd5, 7'd3, 1'b0, 8'h00));
    send_beat(make_req(OP_MAP, 8'd64, 7'd1, 1'b0, 8'h00));
    send_beat(make_req(OP_MAP, FlowMax, BearerMax, 1'b1, HdrMax));
    send_beat(make_req(OP_MAP, 8'd0, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_MAP, QfiMax, BearerMax, 1'b1, 8'h00));
    send_beat(make_req(OP_MAP, QfiMax, 7'd5, 1'b0, 8'h00));
    send_beat(make_req(OpUnknown, FlowMax, BearerMax, 1'b1, HdrMax));
    send_beat(make_req(OpCodeMax, 8'd0, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_DOWNLINK, 8'd0, BearerMax, 1'b0, HdrMax));
    send_beat(make_req(OP_DOWNLINK, 8'd0, 7'd9, 1'b0, 8'hbf));
    send_beat(make_req(OP_DOWNLINK, FlowMax, 7'd0, 1'b1, 8'h00));
    settle();
    configure(1'b1, 1'b0, 7'd0);
    send_beat(make_req(OP_UPLINK, QfiMax, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPLINK, FlowMax, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPLINK, 8'd0, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPDATE, QfiMax, 7'd33, 1'b0, 8'h00));
    send_beat(make_req(OP_UPLINK, QfiMax, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UNMAP, FlowMax, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UNMAP, QfiMax, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPLINK, QfiMax, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPLINK, 8'd17, 7'd0, 1'b0, 8'h00));
    settle();
    configure(1'b1, 1'b1, BearerMax);
    send_beat(make_req(OP_UPLINK, 8'd17, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UPLINK, 8'h80, 7'd0, 1'b0, 8'h00));
    send_beat(make_req(OP_UNMAP, 8'd0, 7'd0, 1'b0, 8'h00));
  endtask

  initial begin
    mix_e        mix;
    int unsigned beat_total;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    // random phases, register extremes first
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      case (p)
        0:       configure(1'b1, 1'b0, 7'd0);
        1:       configure(1'b1, 1'b1, BearerMax);
        2:       configure(1'b0, 1'b1, 7'd0);
        3:       configure(1'b1, 1'b1, 7'd0);
        default: configure($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                           BearerW'($urandom_range(0, BearerMax)));
      endcase
      mix        = mix_e'(p % 3);
      beat_total = (mix == MIX_FILL) ? 110 : 65;
      repeat (beat_total) send_beat(random_req(mix));
    end
    settle();
    repeat (ScanCycles + 10) @(posedge clk_i);
    if (sb.mismatches == 0) $display("PASS qos_flow_to_bearer_mapper");
    else $display("FAIL qos_flow_to_bearer_mapper");
    $finish;
  end

endmodule
